// ===== rtl/ppsk_pkg.sv =====
// Package: shared widths, constants, register codes and item types of the projection block.
package ppsk_pkg;

    localparam int FRAC_BITS = 16;

    localparam int IN_W    = 32;
    localparam int LAYER_W = 16;
    localparam int CFG_W   = 31;
    localparam int W_W     = IN_W + 1;
    localparam int DEN_W   = IN_W;
    localparam int NUM_W   = 2 * CFG_W;
    localparam int KC_W    = 2 * IN_W + 1 - FRAC_BITS + 2;
    localparam int KLO_W   = KC_W / 2;
    localparam int KHI_W   = KC_W - KLO_W;
    localparam int MAG_W   = W_W;
    localparam int PP_W    = KHI_W + MAG_W;
    localparam int PROD_W  = KC_W + MAG_W;
    localparam int SP_W    = PROD_W + 1;
    localparam int SUM_W   = SP_W + 1;
    localparam int KEY_W   = 48;
    localparam int KEY_CALC_W = KEY_W + 4;

    localparam longint NEAR_PLANE = ((64'sd1 <<< FRAC_BITS) + 5) / 10;
    localparam logic [KC_W-1:0] K_CLAMP = KC_W'(1) << (KC_W - 1);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORTHO_MODE,
        REG_PIXELS_PER_METER,
        REG_FOCAL_LENGTH,
        REG_CAMERA_HEIGHT,
        REG_CENTER_X,
        REG_CENTER_Y
    } cfg_idx_t;

    typedef struct packed {
        logic                    ortho_mode;
        logic [CFG_W-1:0]        pixels_per_meter;
        logic [CFG_W-1:0]        focal_length;
        logic signed [IN_W-1:0]  camera_height;
        logic signed [IN_W-1:0]  center_x;
        logic signed [IN_W-1:0]  center_y;
    } cfg_t;

    typedef struct packed {
        logic signed [W_W-1:0]   wx;
        logic signed [W_W-1:0]   wy;
        logic [DEN_W-1:0]        distance;
        logic                    vis;
        logic signed [KEY_W-1:0] depth_key;
    } rec_t;

endpackage

// ===== rtl/ppsk_if.sv =====
// Interfaces: point input channel, projection result channel and register write channel.
interface ppsk_point_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ppsk_pkg::IN_W-1:0]       point_x;
    logic signed [ppsk_pkg::IN_W-1:0]       point_y;
    logic signed [ppsk_pkg::IN_W-1:0]       point_z;
    logic signed [ppsk_pkg::IN_W-1:0]       offset_x;
    logic signed [ppsk_pkg::IN_W-1:0]       offset_y;
    logic signed [ppsk_pkg::IN_W-1:0]       offset_z;
    logic signed [ppsk_pkg::LAYER_W-1:0]    chunk_layer;
    logic                                   upright;

    modport source (output valid, point_x, point_y, point_z, offset_x, offset_y, offset_z,
                    chunk_layer, upright, input ready);
    modport sink (input valid, point_x, point_y, point_z, offset_x, offset_y, offset_z,
                  chunk_layer, upright, output ready);
endinterface

interface ppsk_proj_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ppsk_pkg::IN_W-1:0]       screen_x;
    logic signed [ppsk_pkg::IN_W-1:0]       screen_y;
    logic [ppsk_pkg::CFG_W-1:0]             pixel_scale;
    logic                                   visible;
    logic signed [ppsk_pkg::KEY_W-1:0]      depth_key;

    modport source (output valid, screen_x, screen_y, pixel_scale, visible, depth_key,
                    input ready);
    modport sink (input valid, screen_x, screen_y, pixel_scale, visible, depth_key,
                  output ready);
endinterface

interface ppsk_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [ppsk_pkg::CFG_IDX_W-1:0]         index;
    logic [ppsk_pkg::CFG_DATA_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ppsk_front.sv =====
// Front end: world position, near-plane test and depth sort key of one point.
module ppsk_front (
    ppsk_point_if.sink       point,
    input  ppsk_pkg::cfg_t   cfg,
    output ppsk_pkg::rec_t   rec
);
    logic signed [ppsk_pkg::W_W-1:0]        dist_full;
    logic signed [ppsk_pkg::KEY_CALC_W-1:0] layer_term;
    logic signed [ppsk_pkg::KEY_CALC_W-1:0] z_term;
    logic signed [ppsk_pkg::KEY_CALC_W-1:0] key_full;
    logic signed [ppsk_pkg::KEY_CALC_W-1:0] key_max;
    logic signed [ppsk_pkg::KEY_CALC_W-1:0] key_min;

    always_comb
    begin
        rec.wx = ppsk_pkg::W_W'(point.point_x) + ppsk_pkg::W_W'(point.offset_x);
        rec.wy = ppsk_pkg::W_W'(point.point_y) + ppsk_pkg::W_W'(point.offset_y);
        dist_full = ppsk_pkg::W_W'(cfg.camera_height) - ppsk_pkg::W_W'(point.offset_z);
        rec.distance = dist_full[ppsk_pkg::DEN_W-1:0];
        rec.vis = cfg.ortho_mode || (dist_full > ppsk_pkg::W_W'(ppsk_pkg::NEAR_PLANE));

        layer_term = (ppsk_pkg::KEY_CALC_W'(point.chunk_layer) * 10) <<< ppsk_pkg::FRAC_BITS;
        z_term = (ppsk_pkg::KEY_CALC_W'(point.offset_z) <<< 1)
               + ppsk_pkg::KEY_CALC_W'(point.point_z)
               + (ppsk_pkg::KEY_CALC_W'({1'b0, point.upright}) <<< ppsk_pkg::FRAC_BITS);
        key_full = layer_term + (z_term <<< 12) - ppsk_pkg::KEY_CALC_W'(rec.wy);
        key_max = (ppsk_pkg::KEY_CALC_W'(1) <<< (ppsk_pkg::KEY_W - 1)) - 1;
        key_min = -(ppsk_pkg::KEY_CALC_W'(1) <<< (ppsk_pkg::KEY_W - 1));
        priority if (key_full > key_max)
            rec.depth_key = key_max[ppsk_pkg::KEY_W-1:0];
        else if (key_full < key_min)
            rec.depth_key = key_min[ppsk_pkg::KEY_W-1:0];
        else
            rec.depth_key = key_full[ppsk_pkg::KEY_W-1:0];
    end
endmodule

// ===== rtl/ppsk_fifo.sv =====
// Short queue of classified items between front end and back end.
module ppsk_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ppsk_pkg::rec_t  push_rec,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output ppsk_pkg::rec_t  head
);
    ppsk_pkg::rec_t                     mem_reg [0:ppsk_pkg::FIFO_DEPTH-1];
    logic [ppsk_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg;
    logic [ppsk_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg;
    logic [ppsk_pkg::FIFO_PTR_W:0]      count_reg;

    assign full  = (count_reg == (ppsk_pkg::FIFO_PTR_W+1)'(ppsk_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end
endmodule

// ===== rtl/ppsk_div.sv =====
// Pipelined restoring divider: focal length times scale over depth distance, one bit a stage.
module ppsk_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  ppsk_pkg::rec_t                  in_rec,
    input  ppsk_pkg::cfg_t                  cfg,
    output logic                            out_valid,
    output ppsk_pkg::rec_t                  out_rec,
    output logic [ppsk_pkg::NUM_W-1:0]      quot
);
    localparam int N = ppsk_pkg::NUM_W;

    logic                               v_reg   [0:N];
    ppsk_pkg::rec_t                     rec_reg [0:N];
    logic [ppsk_pkg::DEN_W-1:0]         rem_reg [0:N];
    logic [N-1:0]                       num_reg [0:N];
    logic [N-1:0]                       quo_reg [0:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rec_reg[0] <= in_rec;
            rem_reg[0] <= '0;
            num_reg[0] <= N'(cfg.focal_length) * N'(cfg.pixels_per_meter);
            quo_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < N; j++)
    begin : g_step
        logic [ppsk_pkg::DEN_W:0] trial;
        logic [ppsk_pkg::DEN_W:0] diff;
        logic                     ge;

        assign trial = {rem_reg[j], num_reg[j][N-1]};
        assign diff  = trial - {1'b0, rec_reg[j].distance};
        assign ge    = (trial >= {1'b0, rec_reg[j].distance});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j+1] <= 1'b0;
            else if (en)
                v_reg[j+1] <= v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rec_reg[j+1] <= rec_reg[j];
                rem_reg[j+1] <= ge ? diff[ppsk_pkg::DEN_W-1:0] : trial[ppsk_pkg::DEN_W-1:0];
                num_reg[j+1] <= {num_reg[j][N-2:0], 1'b0};
                quo_reg[j+1] <= {quo_reg[j][N-2:0], ge};
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_rec   = rec_reg[N];
    assign quot      = quo_reg[N];
endmodule

// ===== rtl/ppsk_scale.sv =====
// Back end: select scale, split multiply by world position, add centre, saturate.
module ppsk_scale (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  ppsk_pkg::rec_t                  in_rec,
    input  logic [ppsk_pkg::NUM_W-1:0]      quot,
    input  ppsk_pkg::cfg_t                  cfg,
    ppsk_proj_if.source                     proj
);
    localparam logic [ppsk_pkg::NUM_W-1:0] SCALE_MAX = ppsk_pkg::NUM_W'({ppsk_pkg::CFG_W{1'b1}});

    logic [ppsk_pkg::NUM_W-1:0]             k_full;

    logic                                   a_v_reg, b_v_reg, c_v_reg;
    ppsk_pkg::rec_t                         a_rec_reg, b_rec_reg, c_rec_reg;
    logic [ppsk_pkg::KC_W-1:0]              a_kc_reg;
    logic [ppsk_pkg::CFG_W-1:0]             a_scale_reg, b_scale_reg, c_scale_reg;
    logic [ppsk_pkg::MAG_W-1:0]             a_magx_reg, a_magy_reg;
    logic [ppsk_pkg::PP_W-1:0]              b_lx_reg, b_hx_reg, b_ly_reg, b_hy_reg;
    logic signed [ppsk_pkg::SP_W-1:0]       c_spx_reg, c_spy_reg;

    logic [ppsk_pkg::PROD_W-1:0]            prodx, prody;
    logic signed [ppsk_pkg::SP_W-1:0]       shx, shy;
    logic signed [ppsk_pkg::SUM_W-1:0]      sumx, sumy;
    logic signed [ppsk_pkg::SUM_W-1:0]      s_max, s_min;

    function automatic logic [ppsk_pkg::MAG_W-1:0] magnitude(
        input logic signed [ppsk_pkg::W_W-1:0] w
    );
        logic [ppsk_pkg::MAG_W-1:0] m;
        m = w[ppsk_pkg::W_W-1] ? ppsk_pkg::MAG_W'(-w) : ppsk_pkg::MAG_W'(w);
        return m;
    endfunction

    function automatic logic signed [ppsk_pkg::IN_W-1:0] sat32(
        input logic signed [ppsk_pkg::SUM_W-1:0] v,
        input logic signed [ppsk_pkg::SUM_W-1:0] hi,
        input logic signed [ppsk_pkg::SUM_W-1:0] lo
    );
        logic signed [ppsk_pkg::SUM_W-1:0] r;
        r = (v > hi) ? hi : ((v < lo) ? lo : v);
        return r[ppsk_pkg::IN_W-1:0];
    endfunction

    assign k_full = cfg.ortho_mode ? ppsk_pkg::NUM_W'(cfg.pixels_per_meter) : quot;

    always_comb
    begin
        prodx = (ppsk_pkg::PROD_W'(b_hx_reg) << ppsk_pkg::KLO_W) + ppsk_pkg::PROD_W'(b_lx_reg);
        prody = (ppsk_pkg::PROD_W'(b_hy_reg) << ppsk_pkg::KLO_W) + ppsk_pkg::PROD_W'(b_ly_reg);
        shx   = c_spx_reg >>> ppsk_pkg::FRAC_BITS;
        shy   = c_spy_reg >>> ppsk_pkg::FRAC_BITS;
        sumx  = ppsk_pkg::SUM_W'(shx) + ppsk_pkg::SUM_W'(cfg.center_x);
        sumy  = ppsk_pkg::SUM_W'(shy) + ppsk_pkg::SUM_W'(cfg.center_y);
        s_max = (ppsk_pkg::SUM_W'(1) <<< (ppsk_pkg::IN_W - 1)) - 1;
        s_min = -(ppsk_pkg::SUM_W'(1) <<< (ppsk_pkg::IN_W - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg    <= 1'b0;
            b_v_reg    <= 1'b0;
            c_v_reg    <= 1'b0;
            proj.valid <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg    <= in_valid;
            b_v_reg    <= a_v_reg;
            c_v_reg    <= b_v_reg;
            proj.valid <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_rec_reg   <= in_rec;
            a_kc_reg    <= (k_full > ppsk_pkg::NUM_W'(ppsk_pkg::K_CLAMP)) ?
                           ppsk_pkg::K_CLAMP : k_full[ppsk_pkg::KC_W-1:0];
            a_scale_reg <= (k_full > SCALE_MAX) ? SCALE_MAX[ppsk_pkg::CFG_W-1:0]
                                                : k_full[ppsk_pkg::CFG_W-1:0];
            a_magx_reg  <= magnitude(in_rec.wx);
            a_magy_reg  <= magnitude(in_rec.wy);

            b_rec_reg   <= a_rec_reg;
            b_scale_reg <= a_scale_reg;
            b_lx_reg    <= ppsk_pkg::PP_W'(a_kc_reg[ppsk_pkg::KLO_W-1:0]) * ppsk_pkg::PP_W'(a_magx_reg);
            b_hx_reg    <= ppsk_pkg::PP_W'(a_kc_reg[ppsk_pkg::KC_W-1:ppsk_pkg::KLO_W])
                           * ppsk_pkg::PP_W'(a_magx_reg);
            b_ly_reg    <= ppsk_pkg::PP_W'(a_kc_reg[ppsk_pkg::KLO_W-1:0]) * ppsk_pkg::PP_W'(a_magy_reg);
            b_hy_reg    <= ppsk_pkg::PP_W'(a_kc_reg[ppsk_pkg::KC_W-1:ppsk_pkg::KLO_W])
                           * ppsk_pkg::PP_W'(a_magy_reg);

            c_rec_reg   <= b_rec_reg;
            c_scale_reg <= b_scale_reg;
            c_spx_reg   <= b_rec_reg.wx[ppsk_pkg::W_W-1] ? -$signed({1'b0, prodx})
                                                          : $signed({1'b0, prodx});
            c_spy_reg   <= b_rec_reg.wy[ppsk_pkg::W_W-1] ? -$signed({1'b0, prody})
                                                          : $signed({1'b0, prody});

            proj.visible     <= c_rec_reg.vis;
            proj.depth_key   <= c_rec_reg.depth_key;
            proj.screen_x    <= c_rec_reg.vis ? sat32(sumx, s_max, s_min) : '0;
            proj.screen_y    <= c_rec_reg.vis ? sat32(sumy, s_max, s_min) : '0;
            proj.pixel_scale <= c_rec_reg.vis ? c_scale_reg : '0;
        end
    end
endmodule

// ===== rtl/point_projection_sort_key.sv =====
// Top level: point projection to screen space with near-plane test and depth sort key.
// One point enters per cycle and one result leaves per cycle while the result side takes them.
// From acceptance to result, when nothing stalls, an item passes the queue, the multiply stage that
// takes it from there, 62 stages of the bit-per-stage divider, and four
// scale/saturate stages. A stalled result holds the whole back end; the four-entry queue keeps
// taking points until full.
module point_projection_sort_key (
    input  logic          clk,
    input  logic          rst_n,
    ppsk_point_if.sink    point,
    ppsk_proj_if.source   proj,
    ppsk_cfg_if.sink      cfg
);
    ppsk_pkg::cfg_t                     cfg_reg;
    ppsk_pkg::rec_t                     front_rec;
    ppsk_pkg::rec_t                     head_rec;
    ppsk_pkg::rec_t                     div_rec;
    logic [ppsk_pkg::NUM_W-1:0]         div_quot;
    logic                               div_valid;
    logic                               fifo_full;
    logic                               fifo_empty;
    logic                               back_en;
    logic                               pop;

    assign cfg.ready   = 1'b1;
    assign point.ready = !fifo_full;
    assign back_en     = !proj.valid || proj.ready;
    assign pop         = back_en && !fifo_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ortho_mode       <= 1'b0;
            cfg_reg.pixels_per_meter <= ppsk_pkg::CFG_W'(65536);
            cfg_reg.focal_length     <= ppsk_pkg::CFG_W'(65536);
            cfg_reg.camera_height    <= ppsk_pkg::IN_W'(65536);
            cfg_reg.center_x         <= '0;
            cfg_reg.center_y         <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                ppsk_pkg::REG_ORTHO_MODE:       cfg_reg.ortho_mode <= cfg.data[0];
                ppsk_pkg::REG_PIXELS_PER_METER: cfg_reg.pixels_per_meter <= cfg.data[ppsk_pkg::CFG_W-1:0];
                ppsk_pkg::REG_FOCAL_LENGTH:     cfg_reg.focal_length <= cfg.data[ppsk_pkg::CFG_W-1:0];
                ppsk_pkg::REG_CAMERA_HEIGHT:    cfg_reg.camera_height <= cfg.data;
                ppsk_pkg::REG_CENTER_X:         cfg_reg.center_x <= cfg.data;
                ppsk_pkg::REG_CENTER_Y:         cfg_reg.center_y <= cfg.data;
                default:                        ;
            endcase
        end
    end

    ppsk_front u_front (
        .point (point),
        .cfg   (cfg_reg),
        .rec   (front_rec)
    );

    ppsk_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (point.valid && !fifo_full),
        .push_rec (front_rec),
        .pop      (pop),
        .full     (fifo_full),
        .empty    (fifo_empty),
        .head     (head_rec)
    );

    ppsk_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_valid  (!fifo_empty),
        .in_rec    (head_rec),
        .cfg       (cfg_reg),
        .out_valid (div_valid),
        .out_rec   (div_rec),
        .quot      (div_quot)
    );

    ppsk_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (back_en),
        .in_valid (div_valid),
        .in_rec   (div_rec),
        .quot     (div_quot),
        .cfg      (cfg_reg),
        .proj     (proj)
    );
endmodule

// ===== tb/point_projection_sort_key_tb.sv =====
// Testbench: random and directed points through the projection block, checked against a predictor.
module point_projection_sort_key_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ppsk_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd6;
    localparam longint SCALE_MAG_LIMIT = 64'sd1 <<< 62;
    localparam longint KEY_HI = (64'sd1 <<< 47) - 1;
    localparam longint KEY_LO = -(64'sd1 <<< 47);
    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic signed [15:0] layer;
        logic               up;
    } point_t;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic [30:0]        scale;
        logic               vis;
        logic signed [47:0] key;
    } proj_t;

    class projection_scoreboard;
        proj_t  expected_q[$];
        int     errors;
        logic   ortho;
        longint ppm;
        longint focal;
        longint height;
        longint cx;
        longint cy;

        function new();
            errors = 0;
            ortho = 1'b0;
            ppm = 65536;
            focal = 65536;
            height = 65536;
            cx = 0;
            cy = 0;
        endfunction

        function void set_reg(logic [ppsk_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
            case (idx)
                ppsk_pkg::REG_ORTHO_MODE:       ortho = d[0];
                ppsk_pkg::REG_PIXELS_PER_METER: ppm = longint'({33'd0, d[30:0]});
                ppsk_pkg::REG_FOCAL_LENGTH:     focal = longint'({33'd0, d[30:0]});
                ppsk_pkg::REG_CAMERA_HEIGHT:    height = longint'(signed'(d));
                ppsk_pkg::REG_CENTER_X:         cx = longint'(signed'(d));
                ppsk_pkg::REG_CENTER_Y:         cy = longint'(signed'(d));
                default:                        ;
            endcase
        endfunction

        function longint scaled(longint unsigned k, longint w);
            longint unsigned mag;
            longint prod;
            mag = (w < 0) ? longint'(-w) : longint'(w);
            if (mag != 0 && k > longint'(SCALE_MAG_LIMIT) / mag)
                prod = (w < 0) ? -SCALE_MAG_LIMIT : SCALE_MAG_LIMIT;
            else
                prod = (w < 0) ? -longint'(k * mag) : longint'(k * mag);
            return prod >>> ppsk_pkg::FRAC_BITS;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void note(point_t p);
            proj_t e;
            longint wx, wy, distance, key;
            longint unsigned k;
            wx = longint'(p.px) + longint'(p.ox);
            wy = longint'(p.py) + longint'(p.oy);
            e = '0;
            k = 0;
            if (ortho)
            begin
                k = ppm;
                e.vis = 1'b1;
            end
            else
            begin
                distance = height - longint'(p.oz);
                if (distance > ppsk_pkg::NEAR_PLANE)
                begin
                    k = (longint'(focal) * longint'(ppm)) / longint'(distance);
                    e.vis = 1'b1;
                end
            end
            if (e.vis)
            begin
                e.sx = 32'(clamp(cx + scaled(k, wx), S32_LO, S32_HI));
                e.sy = 32'(clamp(cy + scaled(k, wy), S32_LO, S32_HI));
                e.scale = (k > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : 31'(k);
            end
            key = 10 * longint'(p.layer) * 65536
                + 4096 * (2 * longint'(p.oz) + longint'(p.pz) + longint'(p.up) * 65536) - wy;
            e.key = 48'(clamp(key, KEY_LO, KEY_HI));
            expected_q.push_back(e);
        endfunction

        function void check(proj_t a);
            proj_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result item sx=%0d", a.sx);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (a.sx !== e.sx)
            begin
                $error("screen_x expected %0d actual %0d", e.sx, a.sx);
                errors++;
            end
            if (a.sy !== e.sy)
            begin
                $error("screen_y expected %0d actual %0d", e.sy, a.sy);
                errors++;
            end
            if (a.scale !== e.scale)
            begin
                $error("pixel_scale expected %0d actual %0d", e.scale, a.scale);
                errors++;
            end
            if (a.vis !== e.vis)
            begin
                $error("visible expected %0d actual %0d", e.vis, a.vis);
                errors++;
            end
            if (a.key !== e.key)
            begin
                $error("depth_key expected %0d actual %0d", e.key, a.key);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic steady;
    projection_scoreboard sb;

    ppsk_point_if point ();
    ppsk_proj_if  proj ();
    ppsk_cfg_if   cfg ();

    point_projection_sort_key dut (
        .clk   (clk),
        .rst_n (rst_n),
        .point (point.sink),
        .proj  (proj.source),
        .cfg   (cfg.sink)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("FAIL point_projection_sort_key");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && point.valid && point.ready)
            sb.note({point.point_x, point.point_y, point.point_z, point.offset_x,
                     point.offset_y, point.offset_z, point.chunk_layer, point.upright});
        if (rst_n && proj.valid && proj.ready)
            sb.check({proj.screen_x, proj.screen_y, proj.pixel_scale, proj.visible,
                      proj.depth_key});
    end

    always @(posedge clk)
        proj.ready <= steady || ($urandom_range(99) >= 14);

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2097151)) - 1048576);
            2:
            begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return 32'($signed($urandom_range(33554431)) - 16777216);
        endcase
    endfunction

    function automatic point_t rand_point();
        point_t p;
        p.px = rand_word();
        p.py = rand_word();
        p.pz = rand_word();
        p.ox = rand_word();
        p.oy = rand_word();
        p.oz = rand_word();
        if ($urandom_range(1))
            p.oz = 32'(sb.height - longint'($urandom_range(13107)));
        p.layer = 16'($urandom);
        p.up = 1'($urandom);
        return p;
    endfunction

    task automatic send_point(point_t p);
        while (!steady && $urandom_range(99) < 14)
        begin
            point.valid <= 1'b0;
            @(posedge clk);
        end
        point.valid <= 1'b1;
        {point.point_x, point.point_y, point.point_z, point.offset_x, point.offset_y,
         point.offset_z, point.chunk_layer, point.upright} <= p;
        @(posedge clk);
        while (!point.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        point.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(logic [ppsk_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= d;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        sb.set_reg(idx, d);
        @(posedge clk);
    endtask

    task automatic set_all(logic om, logic [31:0] pm, logic [31:0] fl, logic [31:0] ch,
                           logic [31:0] x0, logic [31:0] y0);
        write_reg(ppsk_pkg::REG_ORTHO_MODE, {31'd0, om});
        write_reg(ppsk_pkg::REG_PIXELS_PER_METER, pm);
        write_reg(ppsk_pkg::REG_FOCAL_LENGTH, fl);
        write_reg(ppsk_pkg::REG_CAMERA_HEIGHT, ch);
        write_reg(ppsk_pkg::REG_CENTER_X, x0);
        write_reg(ppsk_pkg::REG_CENTER_Y, y0);
    endtask

    task automatic random_run(int n);
        for (int i = 0; i < n; i++)
        begin
            steady = (i >= n / 3 && i < n / 3 + 40);
            send_point(rand_point());
        end
        steady = 1'b0;
    endtask

    initial
    begin
        point_t p;
        sb = new();
        steady = 1'b0;
        rst_n = 1'b0;
        point.valid = 1'b0;
        {point.point_x, point.point_y, point.point_z, point.offset_x, point.offset_y,
         point.offset_z, point.chunk_layer, point.upright} = '0;
        cfg.valid = 1'b0;
        cfg.index = ppsk_pkg::REG_ORTHO_MODE;
        cfg.data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // near plane edges at reset height, then field extremes
        p = '0;
        send_point(p);
        p.oz = 32'(65536 - ppsk_pkg::NEAR_PLANE);
        send_point(p);
        p.oz = 32'(65536 - ppsk_pkg::NEAR_PLANE - 1);
        p.px = 32'sd65536;
        p.py = -32'sd65536;
        send_point(p);
        p = '1;
        send_point(p);
        p.px = 32'h7FFF_FFFF;
        p.py = 32'h7FFF_FFFF;
        p.pz = 32'h7FFF_FFFF;
        p.ox = 32'h7FFF_FFFF;
        p.oy = 32'h7FFF_FFFF;
        p.oz = 32'h8000_0000;
        p.layer = 16'h7FFF;
        p.up = 1'b1;
        send_point(p);
        p.px = 32'h8000_0000;
        p.py = 32'h8000_0000;
        p.pz = 32'h8000_0000;
        p.ox = 32'h8000_0000;
        p.oy = 32'h8000_0000;
        p.oz = 32'h8000_0000;
        p.layer = 16'h8000;
        p.up = 1'b0;
        send_point(p);
        p.oz = 32'h7FFF_FFFF;
        p.pz = 32'h7FFF_FFFF;
        p.layer = 16'h7FFF;
        p.up = 1'b1;
        send_point(p);
        for (int i = 0; i < 12; i++)
            send_point(rand_point());
        drain();

        set_all(1'b1, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        random_run(170);
        drain();

        set_all(1'b0, $urandom, $urandom, 32'($urandom_range(2000000)), $urandom, $urandom);
        random_run(90);
        drain();
        random_run(90);
        drain();

        set_all(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h2000, 32'h0, 32'h0);
        random_run(180);
        drain();

        set_all(1'b1, 32'h0, 32'h1_0000, 32'h0, 32'h0, 32'h0);
        random_run(160);
        drain();

        set_all(1'b0, 32'd6553600, 32'd65536, 32'd655360, 32'd41943040, 32'd23592960);
        random_run(200);
        drain();

        set_all(1'b0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h1_0000);
        random_run(180);
        drain();

        if (sb.errors == 0)
            $display("PASS point_projection_sort_key");
        else
            $display("FAIL point_projection_sort_key");
        $finish;
    end
endmodule
